// ===== rtl/core/rlpd_pkg.sv =====
// Shared types, constants and helper function of the run-length pixel decoder.
package rlpd_pkg;

   localparam int CACHE_ENTRIES   = 15;
   localparam int MAX_PIXEL_BYTES = 3;
   localparam int CMD_DEPTH       = 4;
   localparam int CMD_PTR_W       = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W       = $clog2(CMD_DEPTH + 1);

   localparam logic [7:0] RAW_HEADER    = 8'hff;
   localparam logic [3:0] MISS_INDEX    = 4'hf;
   localparam logic [3:0] EXT_RUN       = 4'hf;
   localparam logic [8:0] EXT_RUN_BIAS  = 9'h00e + 9'd1;
   localparam logic [3:0] PRESET_SPLIT  = 4'd7;
   localparam logic [3:0] LAST_ENTRY    = 4'(CACHE_ENTRIES - 1);

   localparam logic [1:0] CSR_LINE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_LINE_COUNT  = 2'd1;
   localparam logic [1:0] CSR_PIXEL_BYTES = 2'd2;

   typedef enum logic [1:0] {
      ST_RUN    = 2'd0,
      ST_RAW    = 2'd1,
      ST_BAD    = 2'd2,
      ST_REPORT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_USE  = 2'd1,
      OP_PUSH = 2'd2
   } cache_op_type;

   typedef struct packed {
      logic         preset;
      logic [1:0]   pixel_bytes;
      cache_op_type cache_op;
      logic [3:0]   index;
      logic [23:0]  pixel;
      logic         emit;
      status_type   status;
      logic [8:0]   run_length;
      logic         line_end;
      logic         image_done;
      logic         image_incomplete;
   } cmd_type;

   // Preset entries: the lowest values at the front, the largest values at the back.
   function automatic logic [23:0] preset_value(input logic [3:0] entry,
                                                input logic [1:0] pixel_bytes);
      logic [23:0] mask;
      case (pixel_bytes)
         2'd1:    mask = 24'h0000ff;
         2'd2:    mask = 24'h00ffff;
         default: mask = 24'hffffff;
      endcase
      if (entry < PRESET_SPLIT) begin
         return {20'd0, entry};
      end
      return mask - {20'd0, LAST_ENTRY - entry};
   endfunction

endpackage

// ===== rtl/core/rlpd_front.sv =====
// Front part: configuration registers, byte parser and line bookkeeping.
module rlpd_front import rlpd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_data,
   input  logic          accept,
   input  logic [7:0]    data_byte,
   input  logic          first_byte,
   input  logic          final_byte,
   output logic          cmd_valid,
   output cmd_type       cmd
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_RAW,
      PH_TOKEN,
      PH_EXT,
      PH_PIXEL
   } phase_type;

   logic [15:0] line_width_ff;
   logic [15:0] line_count_ff;
   logic [1:0]  pixel_bytes_ff;

   phase_type   phase_ff, phase_in, cur_phase;
   logic [15:0] pixels_ff, pixels_in, cur_pixels;
   logic [17:0] raw_ff, raw_in, cur_raw;
   logic [15:0] lines_ff, lines_in, cur_lines;
   logic [8:0]  run_ff, run_in, cur_run;
   logic [3:0]  index_ff, index_in, cur_index;
   logic [23:0] gather_ff, gather_in, cur_gather;
   logic [1:0]  count_ff, count_in, cur_count;
   logic        error_ff, error_in, cur_error;

   logic [1:0]  eff_bytes;
   logic [17:0] raw_total;
   logic        result;
   logic        finish;
   logic        finish_hit;
   logic        line_done;
   logic [1:0]  count_next;

   assign eff_bytes = (pixel_bytes_ff == 2'd0) ? 2'd1 : pixel_bytes_ff;
   assign raw_total = {2'd0, line_width_ff} * {16'd0, eff_bytes};

   always_comb begin
      cur_phase  = first_byte ? PH_HEADER : phase_ff;
      cur_pixels = first_byte ? 16'd0 : pixels_ff;
      cur_raw    = first_byte ? 18'd0 : raw_ff;
      cur_lines  = first_byte ? line_count_ff : lines_ff;
      cur_run    = first_byte ? 9'd0 : run_ff;
      cur_index  = first_byte ? 4'd0 : index_ff;
      cur_gather = first_byte ? 24'd0 : gather_ff;
      cur_count  = first_byte ? 2'd0 : count_ff;
      cur_error  = first_byte ? 1'b0 : error_ff;

      phase_in   = cur_phase;
      pixels_in  = cur_pixels;
      raw_in     = cur_raw;
      lines_in   = cur_lines;
      run_in     = cur_run;
      index_in   = cur_index;
      gather_in  = cur_gather;
      count_in   = cur_count;
      error_in   = cur_error;

      result     = 1'b0;
      finish     = 1'b0;
      finish_hit = 1'b0;
      line_done  = 1'b0;
      count_next = cur_count + 2'd1;

      cmd = '0;
      cmd.pixel_bytes = eff_bytes;
      cmd.cache_op    = OP_NONE;
      cmd.status      = ST_REPORT;

      if (!cur_error && cur_lines != 16'd0) begin
         case (cur_phase)
            PH_HEADER: begin
               if (data_byte == RAW_HEADER) begin
                  raw_in = raw_total;
                  if (raw_total == 18'd0) begin
                     line_done = 1'b1;
                  end else begin
                     phase_in = PH_RAW;
                  end
               end else begin
                  cmd.preset = 1'b1;
                  pixels_in  = line_width_ff;
                  if (line_width_ff == 16'd0) begin
                     line_done = 1'b1;
                  end else begin
                     phase_in = PH_TOKEN;
                  end
               end
            end
            PH_RAW: begin
               result     = 1'b1;
               cmd.status = ST_RAW;
               cmd.pixel  = {16'd0, data_byte};
               if (cur_raw != 18'd0) begin
                  raw_in = cur_raw - 18'd1;
               end
               if (raw_in == 18'd0) begin
                  cmd.line_end = 1'b1;
                  line_done    = 1'b1;
               end
            end
            PH_TOKEN: begin
               index_in  = data_byte[3:0];
               gather_in = 24'd0;
               count_in  = 2'd0;
               if (data_byte[7:4] == EXT_RUN) begin
                  run_in   = {5'd0, data_byte[7:4]};
                  phase_in = PH_EXT;
               end else begin
                  run_in = {5'd0, data_byte[7:4]} + 9'd1;
                  if (data_byte[3:0] == MISS_INDEX) begin
                     phase_in = PH_PIXEL;
                  end else begin
                     finish     = 1'b1;
                     finish_hit = 1'b1;
                  end
               end
            end
            PH_EXT: begin
               run_in = {1'b0, data_byte} + EXT_RUN_BIAS;
               if (cur_index == MISS_INDEX) begin
                  phase_in = PH_PIXEL;
               end else begin
                  finish     = 1'b1;
                  finish_hit = 1'b1;
               end
            end
            PH_PIXEL: begin
               gather_in = {cur_gather[15:0], data_byte};
               count_in  = count_next;
               if (count_next >= eff_bytes) begin
                  count_in = 2'd0;
                  finish   = 1'b1;
               end
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase

         if (finish) begin
            result       = 1'b1;
            cmd.cache_op = finish_hit ? OP_USE : OP_PUSH;
            cmd.index    = index_in;
            cmd.pixel    = gather_in;
            if ({7'd0, run_in} > cur_pixels) begin
               error_in   = 1'b1;
               cmd.status = ST_BAD;
            end else begin
               pixels_in      = cur_pixels - {7'd0, run_in};
               cmd.status     = ST_RUN;
               cmd.run_length = run_in;
               if (pixels_in == 16'd0) begin
                  cmd.line_end = 1'b1;
                  line_done    = 1'b1;
               end else begin
                  phase_in = PH_TOKEN;
               end
            end
         end

         if (line_done) begin
            lines_in = cur_lines - 16'd1;
            phase_in = PH_HEADER;
         end
      end

      cmd.emit             = result || final_byte;
      cmd.image_done       = !error_in && lines_in == 16'd0;
      cmd.image_incomplete = final_byte && !cmd.image_done;
      cmd_valid = cmd.emit || cmd.preset || cmd.cache_op != OP_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff  <= 16'd1;
         line_count_ff  <= 16'd0;
         pixel_bytes_ff <= 2'd1;
         phase_ff       <= PH_HEADER;
         pixels_ff      <= 16'd0;
         raw_ff         <= 18'd0;
         lines_ff       <= 16'd0;
         run_ff         <= 9'd0;
         index_ff       <= 4'd0;
         gather_ff      <= 24'd0;
         count_ff       <= 2'd0;
         error_ff       <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_LINE_WIDTH:  line_width_ff  <= csr_data;
               CSR_LINE_COUNT:  line_count_ff  <= csr_data;
               CSR_PIXEL_BYTES: pixel_bytes_ff <= csr_data[1:0];
               default: ;
            endcase
         end
         if (accept) begin
            phase_ff  <= phase_in;
            pixels_ff <= pixels_in;
            raw_ff    <= raw_in;
            lines_ff  <= lines_in;
            run_ff    <= run_in;
            index_ff  <= index_in;
            gather_ff <= gather_in;
            count_ff  <= count_in;
            error_ff  <= error_in;
         end
      end
   end

endmodule

// ===== rtl/core/rlpd_cmd_fifo.sv =====
// Short command queue between the parser and the cache back end.
module rlpd_cmd_fifo import rlpd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    empty
);

   cmd_type              slot_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full    = count_ff == CMD_CNT_W'(CMD_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + CMD_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + CMD_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CMD_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CMD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/core/rlpd_back.sv =====
// Back part: move-to-front pixel cache and the result output register.
module rlpd_back import rlpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_take,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_status,
   output logic [8:0]  rsp_run_length,
   output logic [23:0] rsp_pixel_value,
   output logic        rsp_cache_hit,
   output logic        rsp_line_end,
   output logic        rsp_image_done,
   output logic        rsp_image_incomplete
);

   logic [23:0] cache_ff [CACHE_ENTRIES];
   logic [23:0] cache_in [CACHE_ENTRIES];
   logic [23:0] hit_pixel;
   logic [23:0] out_pixel;
   logic        out_valid_ff, out_valid_in;

   assign cmd_take  = cmd_valid && (!out_valid_ff || rsp_pop);
   assign hit_pixel = cache_ff[cmd.index];
   assign rsp_empty = !out_valid_ff;

   always_comb begin
      for (int e = 0; e < CACHE_ENTRIES; e++) begin
         cache_in[e] = cache_ff[e];
         if (cmd.preset) begin
            cache_in[e] = preset_value(4'(e), cmd.pixel_bytes);
         end else if (cmd.cache_op == OP_USE) begin
            if (e == 0) begin
               cache_in[e] = hit_pixel;
            end else if (4'(e) <= cmd.index) begin
               cache_in[e] = cache_ff[e-1];
            end
         end else if (cmd.cache_op == OP_PUSH) begin
            cache_in[e] = (e == 0) ? cmd.pixel : cache_ff[e-1];
         end
      end

      case (cmd.status)
         ST_RUN:  out_pixel = (cmd.cache_op == OP_USE) ? hit_pixel : cmd.pixel;
         ST_RAW:  out_pixel = cmd.pixel;
         default: out_pixel = 24'd0;
      endcase

      out_valid_in = out_valid_ff && !rsp_pop;
      if (cmd_take) begin
         out_valid_in = cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_take) begin
         for (int e = 0; e < CACHE_ENTRIES; e++) begin
            cache_ff[e] <= cache_in[e];
         end
         if (cmd.emit) begin
            rsp_status           <= cmd.status;
            rsp_run_length       <= cmd.run_length;
            rsp_pixel_value      <= out_pixel;
            rsp_cache_hit        <= cmd.status == ST_RUN && cmd.cache_op == OP_USE;
            rsp_line_end         <= cmd.line_end;
            rsp_image_done       <= cmd.image_done;
            rsp_image_incomplete <= cmd.image_incomplete;
         end
      end
   end

endmodule

// ===== rtl/core/lru_run_length_pixel_decoder.sv =====
// Top level of the move-to-front cache run-length pixel decoder.
//
//   channel  direction  handshake              word
//   req      in         push / full            data_byte, first_byte, final_byte
//   rsp      out        pop / empty            status, run_length, pixel_value, flags
//   csr      in         write, index, data     line_width, line_count, pixel_bytes
//
// One byte per cycle is accepted unless full; the parser decides its effect in that cycle.
// Results wait in the command queue behind earlier work, then enter the output register;
// the cache back end retires one command a cycle while that register is free or popped.
// Full rises only while the four-entry command queue is full because results wait.
// Reset is synchronous; the cache is loaded at each encoded line.
module lru_run_length_pixel_decoder import rlpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic        req_final_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_status,
   output logic [8:0]  rsp_run_length,
   output logic [23:0] rsp_pixel_value,
   output logic        rsp_cache_hit,
   output logic        rsp_line_end,
   output logic        rsp_image_done,
   output logic        rsp_image_incomplete
);

   logic    accept;
   logic    front_valid;
   cmd_type front_cmd;
   cmd_type queue_cmd;
   logic    queue_empty;
   logic    back_take;

   assign accept = req_push && !req_full;

   rlpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .first_byte (req_first_byte),
      .final_byte (req_final_byte),
      .cmd_valid  (front_valid),
      .cmd        (front_cmd)
   );

   rlpd_cmd_fifo u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept && front_valid),
      .push_cmd (front_cmd),
      .full     (req_full),
      .pop      (back_take),
      .pop_cmd  (queue_cmd),
      .empty    (queue_empty)
   );

   rlpd_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cmd_valid            (!queue_empty),
      .cmd                  (queue_cmd),
      .cmd_take             (back_take),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_status           (rsp_status),
      .rsp_run_length       (rsp_run_length),
      .rsp_pixel_value      (rsp_pixel_value),
      .rsp_cache_hit        (rsp_cache_hit),
      .rsp_line_end         (rsp_line_end),
      .rsp_image_done       (rsp_image_done),
      .rsp_image_incomplete (rsp_image_incomplete)
   );

endmodule

// ===== rtl/core/rlpd_checker.sv =====
// Port-level checks of the decoder, bound to its top level.
module rlpd_checker import rlpd_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [1:0]  rsp_status,
   input logic [8:0]  rsp_run_length,
   input logic        rsp_cache_hit,
   input logic        rsp_line_end,
   input logic        rsp_image_done,
   input logic        rsp_image_incomplete
);

   a_reset_clears: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("Decoder not empty after reset.");

   a_word_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_status)
         && $stable(rsp_run_length))
      else $error("Waiting result word changed.");

   a_run_fields: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_status != ST_RUN |-> rsp_run_length == 9'd0 && !rsp_cache_hit)
      else $error("Run fields set on a word that is not a run.");

   a_bad_run: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_status == ST_BAD |-> !rsp_line_end && !rsp_image_done)
      else $error("Bad run word reports line or image completion.");

   a_done_flags: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> !(rsp_image_done && rsp_image_incomplete))
      else $error("Image reported both done and incomplete.");

endmodule

bind lru_run_length_pixel_decoder rlpd_checker u_checker (
   .clock                (clock),
   .reset                (reset),
   .req_full             (req_full),
   .rsp_empty            (rsp_empty),
   .rsp_pop              (rsp_pop),
   .rsp_status           (rsp_status),
   .rsp_run_length       (rsp_run_length),
   .rsp_cache_hit        (rsp_cache_hit),
   .rsp_line_end         (rsp_line_end),
   .rsp_image_done       (rsp_image_done),
   .rsp_image_incomplete (rsp_image_incomplete)
);
